// File: hdl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg : shared types and constants of the CSS rule splitter
// Scan phases, quote kinds, character codes and marker lookup functions.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int DEPTH_BITS_DEF  = 8;
    localparam int EVQ_DEPTH       = 4;   // power of two
    localparam int SPAN_W          = 24;
    localparam int TDATA_IN_W      = 8;
    localparam int TDATA_OUT_W     = 56;

    typedef enum logic [2:0] {
        PH_BETWEEN = 3'd0,
        PH_CDO     = 3'd1,
        PH_CDC     = 3'd2,
        PH_SLASH   = 3'd3,
        PH_COMMENT = 3'd4,
        PH_RULE    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_DOUBLE = 2'd1,
        Q_SINGLE = 2'd2
    } quote_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) ||
               (c == CH_CR) || (c == CH_SPACE);
    endfunction

    // expected byte of "<!--" at the given progress
    function automatic logic [7:0] cdo_char(input logic [1:0] prog);
        logic [7:0] ch;
        unique case (prog)
            2'd0:    ch = CH_LT;
            2'd1:    ch = CH_BANG;
            default: ch = CH_DASH;
        endcase
        return ch;
    endfunction

    // expected byte of "-->" at the given progress
    function automatic logic [7:0] cdc_char(input logic [1:0] prog);
        logic [7:0] ch;
        unique case (prog)
            2'd0, 2'd1: ch = CH_DASH;
            default:    ch = CH_GT;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/crs_scan.sv
// ----------------------------------------------------------------------------
// crs_scan : front end of the rule splitter
// Classifies one byte per transfer, tracks markers, comments, quotes and
// nesting, and produces at most one event (rule span and/or end) per byte.
// ----------------------------------------------------------------------------
module crs_scan #(
    parameter int OFFSET_BITS = crs_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = crs_pkg::DEPTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   ev_push,
    output logic                   ev_rule,
    output logic                   ev_done,
    output logic                   ev_sat,
    output logic [OFFSET_BITS-1:0] ev_start,
    output logic [OFFSET_BITS-1:0] ev_end
);
    import crs_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             prog_reg, prog_next;
    quote_t                 quote_reg, quote_next;
    logic                   skip_reg, skip_next;
    logic                   cmt_reg, cmt_next;
    logic                   star_reg, star_next;
    logic                   pslash_reg, pslash_next;
    logic [DEPTH_BITS-1:0]  brk_reg, brk_next;
    logic [DEPTH_BITS-1:0]  brc_reg, brc_next;
    logic                   block_reg, block_next;
    logic                   at_reg, at_next;
    logic                   sat_reg, sat_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] lastns_reg, lastns_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    // marker / between-rule classification
    phase_t                 mk_phase;
    logic [1:0]             mk_prog;
    logic                   mk_star;
    logic [OFFSET_BITS-1:0] mk_start;
    logic                   begin_rule;
    logic [OFFSET_BITS-1:0] begin_start;

    // rule body scan
    logic                   run;
    logic                   r_end;
    quote_t                 r_quote;
    logic                   r_skip, r_cmt, r_star, r_pslash, r_block, r_at, r_sat;
    logic [DEPTH_BITS-1:0]  r_brk, r_brc;
    logic [OFFSET_BITS-1:0] r_start, r_lastns;

    phase_t                 ph_mid;

    always_comb
    begin
        mk_phase    = phase_reg;
        mk_prog     = prog_reg;
        mk_star     = star_reg;
        mk_start    = start_reg;
        begin_rule  = 1'b0;
        begin_start = start_reg;
        unique case (phase_reg)
            PH_BETWEEN:
            begin
                if (!is_ws(data_byte))
                begin
                    priority if (data_byte == CH_SLASH)
                    begin
                        mk_phase = PH_SLASH;
                        mk_start = pos_reg;
                    end
                    else if (data_byte == CH_LT)
                    begin
                        mk_phase = PH_CDO;
                        mk_prog  = 2'd1;
                        mk_start = pos_reg;
                    end
                    else if (data_byte == CH_DASH)
                    begin
                        mk_phase = PH_CDC;
                        mk_prog  = 2'd1;
                        mk_start = pos_reg;
                    end
                    else
                    begin
                        begin_rule  = 1'b1;
                        begin_start = pos_reg;
                    end
                end
            end
            PH_SLASH:
            begin
                if (data_byte == CH_STAR)
                begin
                    mk_phase = PH_COMMENT;
                    mk_star  = 1'b0;
                end
                else
                begin
                    begin_rule = 1'b1;
                end
            end
            PH_CDO:
            begin
                if (data_byte == cdo_char(prog_reg))
                begin
                    if (prog_reg == 2'd3)
                    begin
                        mk_phase = PH_BETWEEN;
                        mk_prog  = 2'd0;
                    end
                    else
                    begin
                        mk_prog = prog_reg + 2'd1;
                    end
                end
                else
                begin
                    begin_rule = 1'b1;
                end
            end
            PH_CDC:
            begin
                if (data_byte == cdc_char(prog_reg))
                begin
                    if (prog_reg == 2'd2)
                    begin
                        mk_phase = PH_BETWEEN;
                        mk_prog  = 2'd0;
                    end
                    else
                    begin
                        mk_prog = prog_reg + 2'd1;
                    end
                end
                else
                begin
                    begin_rule = 1'b1;
                end
            end
            PH_COMMENT:
            begin
                if (star_reg && data_byte == CH_SLASH)
                begin
                    mk_phase = PH_BETWEEN;
                    mk_star  = 1'b0;
                end
                else
                begin
                    mk_star = (data_byte == CH_STAR);
                end
            end
            PH_RULE:
            begin
            end
            default:
            begin
                mk_phase = PH_BETWEEN;
            end
        endcase
    end

    assign run = begin_rule || (phase_reg == PH_RULE);

    // one byte of rule body; a new rule starts from cleared tracking state
    always_comb
    begin
        logic ps;
        logic [DEPTH_BITS-1:0] brc_dec;
        if (begin_rule)
        begin
            r_quote  = Q_NONE;
            r_skip   = 1'b0;
            r_cmt    = 1'b0;
            r_star   = 1'b0;
            r_pslash = 1'b0;
            r_brk    = '0;
            r_brc    = '0;
            r_block  = 1'b0;
            r_sat    = 1'b0;
            r_start  = begin_start;
            r_lastns = begin_start;
            r_at     = (begin_start == pos_reg) && (data_byte == CH_AT);
        end
        else
        begin
            r_quote  = quote_reg;
            r_skip   = skip_reg;
            r_cmt    = cmt_reg;
            r_star   = star_reg;
            r_pslash = pslash_reg;
            r_brk    = brk_reg;
            r_brc    = brc_reg;
            r_block  = block_reg;
            r_sat    = sat_reg;
            r_start  = start_reg;
            r_lastns = lastns_reg;
            r_at     = at_reg;
        end
        r_end   = 1'b0;
        ps      = 1'b0;
        brc_dec = (r_brc != '0) ? r_brc - 1'b1 : r_brc;

        if (!is_ws(data_byte))
        begin
            r_lastns = pos_reg;
        end

        priority if (r_skip)
        begin
            r_skip   = 1'b0;
            r_pslash = 1'b0;
        end
        else if (r_quote != Q_NONE)
        begin
            r_pslash = 1'b0;
            if (data_byte == CH_BSLASH)
            begin
                r_skip = 1'b1;
            end
            else if ((r_quote == Q_DOUBLE && data_byte == CH_DQUOTE) ||
                     (r_quote == Q_SINGLE && data_byte == CH_SQUOTE))
            begin
                r_quote = Q_NONE;
            end
        end
        else if (r_cmt)
        begin
            if (r_star && data_byte == CH_SLASH)
            begin
                r_cmt  = 1'b0;
                r_star = 1'b0;
            end
            else
            begin
                r_star = (data_byte == CH_STAR);
            end
        end
        else
        begin
            ps       = r_pslash;
            r_pslash = 1'b0;
            priority if (ps && data_byte == CH_STAR)
            begin
                r_cmt  = 1'b1;
                r_star = 1'b0;
            end
            else if (data_byte == CH_SLASH)
            begin
                r_pslash = 1'b1;
            end
            else if (data_byte == CH_DQUOTE)
            begin
                r_quote = Q_DOUBLE;
            end
            else if (data_byte == CH_SQUOTE)
            begin
                r_quote = Q_SINGLE;
            end
            else if (data_byte == CH_BSLASH)
            begin
                r_skip = 1'b1;
            end
            else if (data_byte == CH_LPAREN || data_byte == CH_LBRACK)
            begin
                if (r_brk != DEPTH_MAX)
                    r_brk = r_brk + 1'b1;
                else
                    r_sat = 1'b1;
            end
            else if ((data_byte == CH_RPAREN || data_byte == CH_RBRACK) && r_brk != '0)
            begin
                r_brk = r_brk - 1'b1;
            end
            else if (r_brk != '0)
            begin
                // inside brackets nothing else counts
            end
            else if (data_byte == CH_LBRACE)
            begin
                if (r_brc != DEPTH_MAX)
                    r_brc = r_brc + 1'b1;
                else
                    r_sat = 1'b1;
                r_block = 1'b1;
            end
            else if (data_byte == CH_RBRACE)
            begin
                r_brc = brc_dec;
                r_end = (brc_dec == '0) && r_block;
            end
            else if (data_byte == CH_SEMI && r_at && r_brc == '0)
            begin
                r_end = 1'b1;
            end
        end

        if (!run)
        begin
            r_end = 1'b0;
        end
    end

    assign ph_mid = r_end ? PH_BETWEEN : (run ? PH_RULE : mk_phase);

    // next state
    always_comb
    begin
        phase_next  = ph_mid;
        prog_next   = mk_prog;
        star_next   = mk_star;
        start_next  = mk_start;
        quote_next  = quote_reg;
        skip_next   = skip_reg;
        cmt_next    = cmt_reg;
        pslash_next = pslash_reg;
        brk_next    = brk_reg;
        brc_next    = brc_reg;
        block_next  = block_reg;
        at_next     = at_reg;
        sat_next    = sat_reg;
        lastns_next = lastns_reg;
        pos_next    = pos_reg + 1'b1;
        if (run)
        begin
            prog_next   = 2'd0;
            star_next   = r_star;
            start_next  = r_start;
            quote_next  = r_quote;
            skip_next   = r_skip;
            cmt_next    = r_cmt;
            pslash_next = r_pslash;
            brk_next    = r_brk;
            brc_next    = r_brc;
            block_next  = r_block;
            at_next     = r_at;
            sat_next    = r_end ? 1'b0 : r_sat;
            lastns_next = r_lastns;
        end
        if (last_byte)
        begin
            phase_next  = PH_BETWEEN;
            prog_next   = 2'd0;
            star_next   = 1'b0;
            start_next  = '0;
            quote_next  = Q_NONE;
            skip_next   = 1'b0;
            cmt_next    = 1'b0;
            pslash_next = 1'b0;
            brk_next    = '0;
            brc_next    = '0;
            block_next  = 1'b0;
            at_next     = 1'b0;
            sat_next    = 1'b0;
            lastns_next = '0;
            pos_next    = '0;
        end
    end

    // event to the queue
    always_comb
    begin
        ev_done  = last_byte;
        ev_rule  = r_end || (last_byte && (ph_mid == PH_RULE || ph_mid == PH_SLASH ||
                                            ph_mid == PH_CDO || ph_mid == PH_CDC));
        ev_start = run ? r_start : mk_start;
        ev_end   = (!r_end && ph_mid == PH_RULE) ? r_lastns : pos_reg;
        ev_sat   = run ? r_sat : 1'b0;
        ev_push  = step && (ev_rule || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BETWEEN;
            prog_reg   <= 2'd0;
            quote_reg  <= Q_NONE;
            skip_reg   <= 1'b0;
            cmt_reg    <= 1'b0;
            star_reg   <= 1'b0;
            pslash_reg <= 1'b0;
            brk_reg    <= '0;
            brc_reg    <= '0;
            block_reg  <= 1'b0;
            at_reg     <= 1'b0;
            sat_reg    <= 1'b0;
            start_reg  <= '0;
            lastns_reg <= '0;
            pos_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            prog_reg   <= prog_next;
            quote_reg  <= quote_next;
            skip_reg   <= skip_next;
            cmt_reg    <= cmt_next;
            star_reg   <= star_next;
            pslash_reg <= pslash_next;
            brk_reg    <= brk_next;
            brc_reg    <= brc_next;
            block_reg  <= block_next;
            at_reg     <= at_next;
            sat_reg    <= sat_next;
            start_reg  <= start_next;
            lastns_reg <= lastns_next;
            pos_reg    <= pos_next;
        end
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> pos_reg == '0 && phase_reg == PH_BETWEEN)
        else $error("scanner did not restart after final byte");
    a_cdc_progress: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CDC |-> prog_reg == 2'd1 || prog_reg == 2'd2)
        else $error("CDC marker progress out of range");
`endif

endmodule

// File: hdl/crs_evq.sv
// ----------------------------------------------------------------------------
// crs_evq : event queue between scanner and emitter
// Small register FIFO, one write and one read per cycle.
// ----------------------------------------------------------------------------
module crs_evq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = crs_pkg::EVQ_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             nonempty
);
    import crs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("event queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("event queue underflow");
`endif

endmodule

// File: hdl/crs_emit.sv
// ----------------------------------------------------------------------------
// crs_emit : back end of the rule splitter
// Expands queued events into result transfers through an output register;
// an event with a span and the stream end gives two results.
// ----------------------------------------------------------------------------
module crs_emit #(
    parameter int OFFSET_BITS = crs_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic                   q_rule,
    input  logic                   q_done,
    input  logic                   q_sat,
    input  logic [OFFSET_BITS-1:0] q_start,
    input  logic [OFFSET_BITS-1:0] q_end,
    output logic                   q_pop,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   out_has_span,
    output logic                   out_done,
    output logic                   out_sat,
    output logic [OFFSET_BITS-1:0] out_start,
    output logic [OFFSET_BITS-1:0] out_end
);
    import crs_pkg::*;

    logic                   valid_reg, valid_next;
    logic                   pend_reg, pend_next;   // end marker still owed
    logic                   has_reg, has_next;
    logic                   done_reg, done_next;
    logic                   sat_reg, sat_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] end_reg, end_next;
    logic                   load;

    assign load  = !valid_reg || out_ready;
    assign q_pop = load && !pend_reg && q_valid;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        has_next   = has_reg;
        done_next  = done_reg;
        sat_next   = sat_reg;
        start_next = start_reg;
        end_next   = end_reg;
        if (load)
        begin
            priority if (pend_reg || (q_valid && !q_rule))
            begin
                valid_next = 1'b1;
                pend_next  = 1'b0;
                has_next   = 1'b0;
                done_next  = 1'b1;
                sat_next   = 1'b0;
                start_next = '0;
                end_next   = '0;
            end
            else if (q_valid)
            begin
                valid_next = 1'b1;
                pend_next  = q_done;
                has_next   = 1'b1;
                done_next  = 1'b0;
                sat_next   = q_sat;
                start_next = q_start;
                end_next   = q_end;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        has_reg   <= has_next;
        done_reg  <= done_next;
        sat_reg   <= sat_next;
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign out_valid    = valid_reg;
    assign out_has_span = has_reg;
    assign out_done     = done_reg;
    assign out_sat      = sat_reg;
    assign out_start    = start_reg;
    assign out_end      = end_reg;

`ifndef SYNTHESIS
    a_pend_behind_span: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg && has_reg)
        else $error("owed end marker without a span result in front of it");
`endif

endmodule

// File: hdl/css_top_level_rule_splitter_unit.sv
// ----------------------------------------------------------------------------
// css_top_level_rule_splitter_unit : top-level CSS rule splitter
// Splits a byte stream into top-level rule spans; scanner front end, event
// queue and output back end.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser    | tlast
//  s_*     | in  | [7:0] data_byte                    | -        | last_byte
//  m_*     | out | [23:0] span_start, [47:24] span_end | has_span | stream_done
//          |     | [48] depth_saturated, [55:49] zero |          |
//
//  One byte is taken per cycle while s_tready is high; the scanner updates all rule
//  state in the cycle of the transfer. The event of a byte is written to the
//  queue at the edge of its transfer and from there into the output register. A
//  final byte that closes an open rule yields two results, the span and then the
//  end marker. The 4-entry event queue lets the scanner keep taking bytes while
//  the output is stalled; s_tready drops only when it is full. Reset clears all
//  control state (not the queue slots or output data registers); no clearing pass.
// ----------------------------------------------------------------------------
module css_top_level_rule_splitter_unit #(
    parameter int OFFSET_BITS = crs_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = crs_pkg::DEPTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [crs_pkg::TDATA_IN_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [23:0] span_start, [47:24] span_end, [48] depth_saturated, rest zero
    output logic [crs_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic                             m_tuser,   // [0] has_span
    output logic                             m_tlast
);
    import crs_pkg::*;

    localparam int EV_W = 2 * OFFSET_BITS + 3;

    logic                   step;
    logic                   ev_push, ev_rule, ev_done, ev_sat;
    logic [OFFSET_BITS-1:0] ev_start, ev_end;
    logic [EV_W-1:0]        q_wdata, q_rdata;
    logic                   q_full, q_nonempty, q_pop;
    logic                   out_sat;
    logic [OFFSET_BITS-1:0] out_start, out_end;

    assign s_tready = !q_full;
    assign step     = s_tvalid && s_tready;

    crs_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s_tdata[7:0]),
        .last_byte (s_tlast),
        .ev_push   (ev_push),
        .ev_rule   (ev_rule),
        .ev_done   (ev_done),
        .ev_sat    (ev_sat),
        .ev_start  (ev_start),
        .ev_end    (ev_end)
    );

    assign q_wdata = {ev_sat, ev_done, ev_rule, ev_end, ev_start};

    crs_evq #(
        .WIDTH (EV_W),
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (ev_push),
        .wdata    (q_wdata),
        .pop      (q_pop),
        .rdata    (q_rdata),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    crs_emit #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_nonempty),
        .q_rule       (q_rdata[2*OFFSET_BITS]),
        .q_done       (q_rdata[2*OFFSET_BITS+1]),
        .q_sat        (q_rdata[2*OFFSET_BITS+2]),
        .q_start      (q_rdata[OFFSET_BITS-1:0]),
        .q_end        (q_rdata[2*OFFSET_BITS-1:OFFSET_BITS]),
        .q_pop        (q_pop),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_has_span (m_tuser),
        .out_done     (m_tlast),
        .out_sat      (out_sat),
        .out_start    (out_start),
        .out_end      (out_end)
    );

    assign m_tdata = {7'b0, out_sat, SPAN_W'(out_end), SPAN_W'(out_start)};

endmodule
